// ===== rtl/nibble_frame_receiver_defines.svh =====
// Assertion macros for the nibble frame receiver.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef NIBBLE_FRAME_RECEIVER_DEFINES_SVH
`define NIBBLE_FRAME_RECEIVER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define NFR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nibble_frame_receiver: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define NFR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nibble_frame_receiver: next-cycle check failed");

`endif

// ===== rtl/nfr_pkg.sv =====
// Shared types and constants for the nibble frame receiver.
// No dependencies; imported by the core, output buffer and top level.
package nfr_pkg;

	localparam int NibbleW = 4;
	localparam int ByteW   = 8;
	localparam int IndexW  = 1;

	// Configuration register indexes
	localparam logic [IndexW-1:0] REG_FIRST_START  = 1'd0;
	localparam logic [IndexW-1:0] REG_SECOND_START = 1'd1;

	// Reset values of the configuration registers
	localparam logic [NibbleW-1:0] FIRST_START_RST  = 4'd3;
	localparam logic [NibbleW-1:0] SECOND_START_RST = 4'd4;

	// End-of-frame marker bytes
	localparam logic [ByteW-1:0] CHAR_E = 8'h45;
	localparam logic [ByteW-1:0] CHAR_N = 8'h4E;
	localparam logic [ByteW-1:0] CHAR_D = 8'h44;

	// Start gap handling
	localparam logic [2:0] GAP_LOCK = 3'd4;
	localparam logic [2:0] GAP_MAX  = 3'd5;

	// Sample phases of interest
	localparam logic [2:0] PHASE_LOW  = 3'd4;
	localparam logic [2:0] PHASE_HIGH = 3'd0;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data_byte;
		logic             frame_end;
	} nfr_result_t;

endpackage

// ===== rtl/nfr_core.sv =====
// Framing core: start pattern hunt, phase counter, byte assembly, END detection.
// Depends on nfr_pkg.
module nfr_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [nfr_pkg::IndexW-1:0]    wr_index,
	input  logic [nfr_pkg::NibbleW-1:0]   wr_data,
	input  logic                          accept,
	input  logic [nfr_pkg::NibbleW-1:0]   sample_nibble,
	output nfr_pkg::nfr_result_t          result
);
	import nfr_pkg::*;

	typedef enum logic [1:0] {
		MODE_HUNT   = 2'd0,
		MODE_LOCKED = 2'd1,
		MODE_DONE   = 2'd2
	} mode_t;

	mode_t              mode_q, mode_d;
	logic [NibbleW-1:0] first_start_q, second_start_q;
	logic               first_seen_q, first_seen_d;
	logic [2:0]         gap_q, gap_d, gap_eff;
	logic [2:0]         phase_q, phase_d;
	logic [NibbleW-1:0] low_q, low_d;
	logic [ByteW-1:0]   last_q, last_d, before_q, before_d;
	logic [ByteW-1:0]   byte_c;
	logic               end_c;

	// Assemble the candidate byte and check the END marker
	assign byte_c = {sample_nibble, low_q};
	assign end_c  = (byte_c == CHAR_D) && (last_q == CHAR_N) && (before_q == CHAR_E);

	// Next state for one accepted sample
	always_comb begin
		mode_d       = mode_q;
		first_seen_d = first_seen_q;
		gap_d        = gap_q;
		gap_eff      = gap_q;
		phase_d      = phase_q;
		low_d        = low_q;
		last_d       = last_q;
		before_d     = before_q;
		result       = '0;
		result.data_byte = byte_c;
		result.frame_end = end_c;
		case (mode_q)
			MODE_HUNT: begin
				// restart the gap on a first start nibble
				if (sample_nibble == first_start_q) begin
					first_seen_d = 1'b1;
					gap_eff      = 3'd0;
				end
				gap_d = gap_eff;
				if (gap_eff == GAP_LOCK && sample_nibble == second_start_q && first_seen_d) begin
					mode_d   = MODE_LOCKED;
					phase_d  = 3'd1;
					low_d    = '0;
					last_d   = '0;
					before_d = '0;
				end else if (gap_eff < GAP_MAX) begin
					gap_d = gap_eff + 3'd1;
				end
			end
			MODE_LOCKED: begin
				phase_d = phase_q + 3'd1;
				if (phase_q == PHASE_LOW) begin
					low_d = sample_nibble;
				end else if (phase_q == PHASE_HIGH) begin
					result.valid = accept;
					before_d     = last_q;
					last_d       = byte_c;
					if (end_c) begin
						mode_d = MODE_DONE;
					end
				end
			end
			default: begin
				// done: drop every sample
			end
		endcase
	end

	// Hold configuration and framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_start_q  <= FIRST_START_RST;
			second_start_q <= SECOND_START_RST;
			mode_q         <= MODE_HUNT;
			first_seen_q   <= 1'b0;
			gap_q          <= '0;
			phase_q        <= '0;
			low_q          <= '0;
			last_q         <= '0;
			before_q       <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_FIRST_START:  first_start_q  <= wr_data;
					REG_SECOND_START: second_start_q <= wr_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				mode_q       <= mode_d;
				first_seen_q <= first_seen_d;
				gap_q        <= gap_d;
				phase_q      <= phase_d;
				low_q        <= low_d;
				last_q       <= last_d;
				before_q     <= before_d;
			end
		end
	end

endmodule

// ===== rtl/nfr_out_buf.sv =====
// Two-entry output stage: result register plus skid register.
// Depends on nfr_pkg.
module nfr_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  nfr_pkg::nfr_result_t        push,
	output logic                        full,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [nfr_pkg::ByteW-1:0]   data_byte,
	output logic                        frame_end
);
	import nfr_pkg::*;

	logic             main_v_q, skid_v_q;
	logic [ByteW-1:0] main_byte_q, skid_byte_q;
	logic             main_end_q, skid_end_q;
	logic             pop;

	assign pop       = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign data_byte = main_byte_q;
	assign frame_end = main_end_q;

	// Control: advance skid into main, or load a new request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push.valid) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	// Payload: no reset needed
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_byte_q <= skid_byte_q;
				main_end_q  <= skid_end_q;
			end
		end else if (push.valid) begin
			if (main_v_q && !pop) begin
				skid_byte_q <= push.data_byte;
				skid_end_q  <= push.frame_end;
			end else begin
				main_byte_q <= push.data_byte;
				main_end_q  <= push.frame_end;
			end
		end
	end

endmodule

// ===== rtl/nibble_frame_receiver.sv =====
// Top level of the nibble frame receiver.
// Depends on nfr_pkg, nfr_core, nfr_out_buf and nibble_frame_receiver_defines.svh.
//
// Usage:
//   Input channel: sample_nibble with in_valid / in_stall; one request is one
//   4-bit sample. Output channel: data_byte and frame_end with out_valid /
//   out_stall; one request is one assembled byte.
//   Configuration: wr_en, wr_index, wr_data write the first (index 0) and
//   second (index 1) start nibbles; write only while the block is idle.
//   Throughput: one sample per cycle while in_stall is low, limited by the
//   framing core which updates all its state for each accepted sample.
//   Output: a byte's accepted high nibble loads it into the result register
//   (the skid register if that is still held); one byte per eight samples.
//   Stall: results sit in a result register backed by a skid register;
//   in_stall rises only when both are full, i.e. after out_stall has held
//   a byte while another one completed.
//   Reset: arst_n clears the framing state to hunting, reloads start nibbles
//   3 and 4 and empties the output stage. After the byte that completes
//   'E','N','D' (flagged by frame_end) samples are consumed and dropped
//   until the next reset.
`include "nibble_frame_receiver_defines.svh"

module nibble_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [nfr_pkg::IndexW-1:0]    wr_index,
	input  logic [nfr_pkg::NibbleW-1:0]   wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [nfr_pkg::NibbleW-1:0]   sample_nibble,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [nfr_pkg::ByteW-1:0]     data_byte,
	output logic                          frame_end
);
	import nfr_pkg::*;

	nfr_result_t result;
	logic        full;
	logic        accept;

	// Accept a sample whenever the skid register is free
	assign in_stall = full;
	assign accept   = in_valid && !full;

	nfr_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.accept        (accept),
		.sample_nibble (sample_nibble),
		.result        (result)
	);

	nfr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (result),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.data_byte (data_byte),
		.frame_end (frame_end)
	);

	// A full skid register implies the result register is occupied
	`NFR_ASSERT_SAME(a_skid_implies_main, in_stall, out_valid)
	// A result is produced only from an accepted sample
	`NFR_ASSERT_SAME(a_result_needs_accept, result.valid, accept)
	// Nothing follows the frame end byte
	`NFR_ASSERT_NEXT(a_quiet_after_end, result.valid && result.frame_end, !result.valid)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for nibble_frame_receiver: start hunting, byte assembly,
// END marker detection, output back-pressure. Depends on nfr_pkg and the RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nfr_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES    = 16;
	localparam int MAX_REPORTS   = 10;

	typedef enum logic [1:0] {HUNTING, LOCKED, FINISHED} rx_mode_e;

	typedef struct packed {
		logic [ByteW-1:0] data_byte;
		logic             frame_end;
	} rx_byte_t;

	// Tracks framing state and holds the bytes the block still owes
	class frame_byte_tracker;
		logic [NibbleW-1:0] first_nib;
		logic [NibbleW-1:0] second_nib;
		rx_mode_e           mode;
		bit                 seen_first;
		logic [2:0]         gap;
		logic [2:0]         phase;
		logic [NibbleW-1:0] low_nib;
		logic [ByteW-1:0]   last_byte;
		logic [ByteW-1:0]   byte_before_last;
		rx_byte_t           expected_bytes[$];
		int                 mismatches;

		function new();
			first_nib        = FIRST_START_RST;
			second_nib       = SECOND_START_RST;
			mode             = HUNTING;
			seen_first       = 1'b0;
			gap              = '0;
			phase            = '0;
			low_nib          = '0;
			last_byte        = '0;
			byte_before_last = '0;
			mismatches       = 0;
		endfunction

		function void write_start(logic [IndexW-1:0] idx, logic [NibbleW-1:0] v);
			if (idx == REG_FIRST_START)
				first_nib = v;
			else if (idx == REG_SECOND_START)
				second_nib = v;
		endfunction

		function void sample_accepted(logic [NibbleW-1:0] s);
			logic [2:0]       cur;
			logic [ByteW-1:0] b;
			logic             fe;
			case (mode)
				HUNTING: begin
					// a first start nibble always restarts the gap
					if (s == first_nib) begin
						seen_first = 1'b1;
						gap = '0;
					end
					if (gap == GAP_LOCK && s == second_nib && seen_first) begin
						mode = LOCKED;
						phase = 3'd1;
						low_nib = '0;
						last_byte = '0;
						byte_before_last = '0;
					end else if (gap < GAP_MAX) begin
						gap = gap + 3'd1;
					end
				end
				LOCKED: begin
					cur = phase;
					phase = phase + 3'd1;
					if (cur == PHASE_LOW) begin
						low_nib = s;
					end else if (cur == PHASE_HIGH) begin
						b = {s, low_nib};
						fe = (b == CHAR_D) && (last_byte == CHAR_N) && (byte_before_last == CHAR_E);
						expected_bytes.push_back('{data_byte: b, frame_end: fe});
						byte_before_last = last_byte;
						last_byte = b;
						if (fe)
							mode = FINISHED;
					end
				end
				default: ;
			endcase
		endfunction

		function void byte_arrived(logic [ByteW-1:0] d, logic fe);
			rx_byte_t want;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected byte %h frame_end %b", $time, d, fe);
			end else begin
				want = expected_bytes.pop_front();
				if (d !== want.data_byte || fe !== want.frame_end) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: data_byte exp %h got %h, frame_end exp %b got %b",
							$time, want.data_byte, d, want.frame_end, fe);
				end
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                wr_en         = 1'b0;
	logic [IndexW-1:0]   wr_index      = '0;
	logic [NibbleW-1:0]  wr_data       = '0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic [NibbleW-1:0]  sample_nibble = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic [ByteW-1:0]    data_byte;
	logic                frame_end;

	frame_byte_tracker sb = new();
	int unsigned       sender_idle_pct   = 29;
	int unsigned       receiver_idle_pct = 77;
	bit                hold_off_req      = 1'b0;
	int                items_sent        = 0;

	nibble_frame_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_nibble (sample_nibble),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.data_byte     (data_byte),
		.frame_end     (frame_end)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Check every delivered byte; accepted samples are noted by the sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.byte_arrived(data_byte, frame_end);
		end
	end

	// Receiver: random stall, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// Offer one sample, idling first at random, wait until it is taken, then note it
	task automatic offer_nibble(input logic [NibbleW-1:0] s);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample_nibble <= s;
		do @(posedge clk); while (in_stall);
		sb.sample_accepted(s);
		items_sent++;
	endtask

	// One byte as eight samples: low nibble at phase 4, high nibble at phase 0, filler elsewhere
	task automatic offer_byte(input logic [ByteW-1:0] b);
		for (int k = 0; k < 8; k++) begin
			if (k == 3)
				offer_nibble(b[3:0]);
			else if (k == 7)
				offer_nibble(b[7:4]);
			else
				offer_nibble(4'($urandom_range(15)));
		end
	endtask

	// Drop valid and hold until every owed byte has come out
	task automatic pause_link();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start_nibble(input logic [IndexW-1:0] idx,
			input logic [NibbleW-1:0] v);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= v;
		@(posedge clk);
		sb.write_start(idx, v);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Bias toward marker letters and extremes, but never close the marker early
	function automatic logic [ByteW-1:0] pick_byte();
		logic [ByteW-1:0] b;
		case ($urandom_range(9))
			0: b = CHAR_E;
			1: b = CHAR_N;
			2: b = CHAR_D;
			3: b = '0;
			4: b = '1;
			default: b = 8'($urandom());
		endcase
		if (b == CHAR_D && sb.last_byte == CHAR_N && sb.byte_before_last == CHAR_E)
			b = ~b;
		return b;
	endfunction

	initial begin
		logic [NibbleW-1:0] nibbles[$];
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// second start nibble alone must not lock
		nibbles = '{4'd4, 4'd4, 4'd4, 4'd4, 4'd4};
		foreach (nibbles[k]) offer_nibble(nibbles[k]);
		// wrong nibble at the lock slot, then a late second nibble
		nibbles = '{4'd3, 4'd0, 4'd15, 4'd9, 4'd5, 4'd4};
		foreach (nibbles[k]) offer_nibble(nibbles[k]);
		pause_link();

		// equal start nibbles never lock
		write_start_nibble(REG_FIRST_START, 4'd7);
		write_start_nibble(REG_SECOND_START, 4'd7);
		nibbles = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd7};
		foreach (nibbles[k]) offer_nibble(nibbles[k]);
		pause_link();

		// extreme start nibbles, restart of the gap, then lock
		write_start_nibble(REG_FIRST_START, 4'd15);
		write_start_nibble(REG_SECOND_START, 4'd0);
		nibbles = '{4'd15, 4'd1, 4'd15, 4'd8, 4'd4, 4'd2, 4'd0};
		foreach (nibbles[k]) offer_nibble(nibbles[k]);

		// locked stream, long receiver hold-off midway to fill the output stage
		while (items_sent < 200) offer_byte(pick_byte());
		hold_off_req = 1'b1;
		while (items_sent < 430) offer_byte(pick_byte());
		pause_link();
		write_start_nibble(REG_FIRST_START, 4'($urandom_range(15)));
		write_start_nibble(REG_SECOND_START, 4'($urandom_range(15)));

		sender_idle_pct = 77;
		receiver_idle_pct = 29;
		while (items_sent < 830) offer_byte(pick_byte());
		pause_link();
		write_start_nibble(REG_SECOND_START, 4'($urandom_range(15)));
		write_start_nibble(REG_FIRST_START, 4'($urandom_range(15)));

		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		while (items_sent < 1230) offer_byte(pick_byte());

		// close the frame, then feed samples that must be dropped
		offer_byte(CHAR_E);
		offer_byte(CHAR_N);
		offer_byte(CHAR_D);
		repeat (16) offer_nibble(4'($urandom_range(15)));
		in_valid <= 1'b0;

		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
